// File: hdl/esc_pkg.sv
// Shared types, character codes and defaults for the expression syntax checker.
package esc_pkg;

   // Default bound on parenthesis nesting
   localparam int unsigned MAX_NESTING_DEFAULT = 255;

   // ASCII codes the checker recognises
   localparam logic [7:0] CHAR_OPEN   = 8'h28;  // (
   localparam logic [7:0] CHAR_CLOSE  = 8'h29;  // )
   localparam logic [7:0] CHAR_DOT    = 8'h2E;  // .
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;  // +
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;  // -
   localparam logic [7:0] CHAR_STAR   = 8'h2A;  // *
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;  // /
   localparam logic [7:0] CHAR_ZERO   = 8'h30;  // 0
   localparam logic [7:0] CHAR_NINE   = 8'h39;  // 9
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_CR     = 8'h0D;

   // Character classes
   typedef enum logic [2:0] {
      CLS_DIGIT,
      CLS_DOT,
      CLS_SIGN,     // + or -
      CLS_MULDIV,   // * or /
      CLS_OPEN,
      CLS_CLOSE,
      CLS_SPACE,
      CLS_OTHER
   } char_class_type;

   // One registered request, already classified
   typedef struct packed {
      char_class_type cls;
      logic           present;
      logic           eoe;
   } item_type;

   // Verdict for one expression
   typedef struct packed {
      logic is_valid;
      logic depth_overflow;
   } verdict_type;

endpackage

// File: hdl/expression_syntax_checker_unit.sv
// Expression syntax checker top level: request register, parser state, result register.
//
// Characters of an arithmetic expression arrive on the req_ channel, one
// request per cycle while req_stall is low. req_char_present qualifies
// req_character; a request with req_end_of_expression set closes the
// expression and produces one result on the rsp_ channel (rsp_is_valid,
// rsp_depth_overflow). Requests without the end mark produce no result.
// A request is taken when req_valid is high and req_stall low; a result is
// taken when rsp_valid is high and rsp_stall low.
// An end request passes through the request register, then its verdict is
// captured in the result register, where rsp_valid rises. Throughput: one
// request per cycle while req_stall is low; the depth counter and flags are
// updated once per request.
// When rsp_stall holds a waiting result, requests without the end mark keep
// flowing; an end request waits in the request register and req_stall rises.
// Synchronous reset empties both registers and returns the parser to its
// start state (depth 0, operand expected, no fault).
module expression_syntax_checker_unit
   import esc_pkg::*;
#(
   parameter int unsigned MAX_NESTING = MAX_NESTING_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_character,
   input  logic       req_char_present,
   input  logic       req_end_of_expression,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_is_valid,
   output logic       rsp_depth_overflow
);

   char_class_type req_cls;
   item_type       item_ff;
   logic           item_valid_ff;
   logic           step;
   verdict_type    verdict;
   verdict_type    rsp_ff;
   logic           rsp_valid_ff;
   logic           rsp_free;

   esc_classify u_classify (
      .character (req_character),
      .cls       (req_cls)
   );

   // Advance the held request unless it would overwrite a waiting result
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign step      = item_valid_ff && (!item_ff.eoe || rsp_free);
   assign req_stall = item_valid_ff && !step;

   // Request register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         item_ff.cls     <= req_cls;
         item_ff.present <= req_char_present;
         item_ff.eoe     <= req_end_of_expression;
      end
   end

   esc_state #(
      .MAX_NESTING (MAX_NESTING)
   ) u_state (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .item    (item_ff),
      .verdict (verdict)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= step && item_ff.eoe;
      end
   end

   always_ff @(posedge clock) begin
      if (step && item_ff.eoe) begin
         rsp_ff <= verdict;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_is_valid       = rsp_ff.is_valid;
   assign rsp_depth_overflow = rsp_ff.depth_overflow;

endmodule

// File: hdl/esc_classify.sv
// Character classifier: maps an ASCII code to its syntactic class.
module esc_classify
   import esc_pkg::*;
(
   input  logic [7:0]     character,
   output char_class_type cls
);

   // Order matters only for readability; the ranges do not overlap
   always_comb begin
      unique if (character >= CHAR_ZERO && character <= CHAR_NINE) begin
         cls = CLS_DIGIT;
      end else if (character == CHAR_DOT) begin
         cls = CLS_DOT;
      end else if (character == CHAR_PLUS || character == CHAR_MINUS) begin
         cls = CLS_SIGN;
      end else if (character == CHAR_STAR || character == CHAR_SLASH) begin
         cls = CLS_MULDIV;
      end else if (character == CHAR_OPEN) begin
         cls = CLS_OPEN;
      end else if (character == CHAR_CLOSE) begin
         cls = CLS_CLOSE;
      end else if (character == CHAR_SPACE ||
                   (character >= CHAR_TAB && character <= CHAR_CR)) begin
         cls = CLS_SPACE;
      end else begin
         cls = CLS_OTHER;
      end
   end

endmodule

// File: hdl/esc_state.sv
// Parser state: depth counter and flags, updated once per request, with verdict.
module esc_state
   import esc_pkg::*;
#(
   parameter int unsigned MAX_NESTING = MAX_NESTING_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  item_type    item,
   output verdict_type verdict
);

   localparam int unsigned DepthW = $clog2(MAX_NESTING + 1);
   localparam logic [DepthW-1:0] DepthMax = DepthW'(MAX_NESTING);

   logic [DepthW-1:0] depth_ff, depth_in;
   logic expect_ff, expect_in;
   logic in_num_ff, in_num_in;
   logic dot_ff, dot_in;
   logic failed_ff, failed_in;
   logic ovf_ff, ovf_in;

   // Next state for the current request
   always_comb begin
      logic tail;
      depth_in  = depth_ff;
      expect_in = expect_ff;
      in_num_in = in_num_ff;
      dot_in    = dot_ff;
      failed_in = failed_ff;
      ovf_in    = ovf_ff;
      tail      = 1'b1;

      if (item.present && !failed_ff) begin
         // open number token absorbs digits and dots; a sign inside it is a fault
         if (in_num_ff) begin
            unique case (item.cls)
               CLS_DIGIT: tail = 1'b0;
               CLS_DOT: begin
                  tail = 1'b0;
                  if (dot_ff) failed_in = 1'b1;
                  dot_in = 1'b1;
               end
               CLS_SIGN: begin
                  tail = 1'b0;
                  failed_in = 1'b1;
               end
               default: begin
                  in_num_in = 1'b0;
                  dot_in    = 1'b0;
               end
            endcase
         end

         if (tail) begin
            unique case (item.cls)
               CLS_SPACE: ;
               CLS_OPEN: begin
                  if (depth_ff >= DepthMax) begin
                     ovf_in    = 1'b1;
                     failed_in = 1'b1;
                  end else begin
                     depth_in  = depth_ff + 1'b1;
                     expect_in = 1'b1;
                  end
               end
               CLS_CLOSE: begin
                  if (depth_ff == '0) begin
                     failed_in = 1'b1;
                  end else begin
                     depth_in  = depth_ff - 1'b1;
                     expect_in = 1'b0;
                  end
               end
               CLS_SIGN, CLS_MULDIV: begin
                  if (expect_ff) failed_in = 1'b1;
                  else           expect_in = 1'b1;
               end
               CLS_DIGIT, CLS_DOT: begin
                  in_num_in = 1'b1;
                  dot_in    = (item.cls == CLS_DOT);
                  expect_in = 1'b0;
               end
               default: failed_in = 1'b1;
            endcase
         end
      end

      // verdict is taken from the state after this character
      verdict.is_valid       = !failed_in && depth_in == '0 && !expect_in;
      verdict.depth_overflow = ovf_in;
   end

   // State register; clears on reset and after each end of expression
   always_ff @(posedge clock) begin
      if (reset || (step && item.eoe)) begin
         depth_ff  <= '0;
         expect_ff <= 1'b1;
         in_num_ff <= 1'b0;
         dot_ff    <= 1'b0;
         failed_ff <= 1'b0;
         ovf_ff    <= 1'b0;
      end else if (step) begin
         depth_ff  <= depth_in;
         expect_ff <= expect_in;
         in_num_ff <= in_num_in;
         dot_ff    <= dot_in;
         failed_ff <= failed_in;
         ovf_ff    <= ovf_in;
      end
   end

   // Checks
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DepthMax) else $error("nesting depth above bound");

   a_ovf_fails: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> failed_ff) else $error("overflow without failure");

   a_dot_in_num: assert property (@(posedge clock) disable iff (reset)
      dot_ff |-> in_num_ff) else $error("dot flag outside a number");

   a_clear_after_end: assert property (@(posedge clock) disable iff (reset)
      (step && item.eoe) |=> (depth_ff == '0 && expect_ff && !failed_ff && !ovf_ff))
      else $error("state not cleared after end of expression");

   a_ovf_verdict: assert property (@(posedge clock) disable iff (reset)
      verdict.depth_overflow |-> !verdict.is_valid)
      else $error("overflowed expression reported valid");

endmodule
